FILE: rtl/c8_pkg.sv
package c8_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int MEM_AW        = $clog2(MEM_BYTES);
    localparam int STACK_DEPTH   = 16;
    localparam int STK_AW        = $clog2(STACK_DEPTH);
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_AW        = $clog2(SCREEN_HEIGHT);

    localparam int          FONT_BASE  = 'h50;
    localparam int          FONT_BYTES = 80;
    localparam logic [11:0] PC_START   = 12'h200;
    localparam logic [3:0]  REG_VF     = 4'hF;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_STEP  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_ROW   = 2'd3;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEK  = 4'h3;
    localparam logic [3:0] OP_SNEK = 4'h4;
    localparam logic [3:0] OP_SEV  = 4'h5;
    localparam logic [3:0] OP_LDK  = 4'h6;
    localparam logic [3:0] OP_ADDK = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNEV = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] FX_GET_DT  = 8'h07;
    localparam logic [7:0] FX_WAITKEY = 8'h0A;
    localparam logic [7:0] FX_SET_DT  = 8'h15;
    localparam logic [7:0] FX_SET_ST  = 8'h18;
    localparam logic [7:0] FX_ADD_I   = 8'h1E;
    localparam logic [7:0] FX_FONT    = 8'h29;
    localparam logic [7:0] FX_BCD     = 8'h33;
    localparam logic [7:0] FX_STORE   = 8'h55;
    localparam logic [7:0] FX_LOAD    = 8'h65;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_MEMRD, ST_ROWRD, ST_FH, ST_FL, ST_RX, ST_RY,
        ST_EX, ST_RET, ST_WVF, ST_CLS, ST_D0, ST_D1, ST_BCD, ST_ST0, ST_ST1,
        ST_LD0, ST_LD1, ST_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] res;
        logic       vf;
        logic       has_vf;
        logic       bad;
    } t_alu;

    localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Byte address reduced modulo the memory size.
    function automatic logic [MEM_AW-1:0] mem_idx(input logic [12:0] a);
        logic [MEM_AW+12:0] w;
        w = {{MEM_AW{1'b0}}, a};
        return w[MEM_AW-1:0];
    endfunction

    function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
        logic [31:0] off;
        off = 32'(a) - 32'(FONT_BASE);
        if (32'(a) >= 32'(FONT_BASE) && off < 32'(FONT_BYTES)) begin
            return GLYPHS[off[6:0]];
        end
        return 8'h00;
    endfunction

    function automatic logic [3:0] high_bit(input logic [15:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (v[i]) n = 4'(i);
        end
        return n;
    endfunction

    // Decimal digit of v: sel 0 hundreds, 1 tens, 2 ones. Divisions use reciprocals.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [15:0] ph;
        logic [15:0] pt;
        logic [7:0]  h;
        logic [7:0]  r;
        logic [7:0]  t;
        ph = 16'(v) * 16'd41;
        h  = {6'd0, ph[13:12]};
        r  = v - 8'(h * 8'd100);
        pt = 16'(r) * 16'd205;
        t  = {4'd0, pt[14:11]};
        case (sel)
            2'd0:    return h;
            2'd1:    return t;
            default: return r - 8'(t * 8'd10);
        endcase
    endfunction

endpackage

FILE: rtl/c8_ram.sv
module c8_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/c8_alu.sv
module c8_alu (
    input  logic [3:0]     i_func,
    input  logic [7:0]     i_vx,
    input  logic [7:0]     i_vy,
    output c8_pkg::t_alu   o_alu
);
    logic [8:0] sum;

    assign sum = {1'b0, i_vx} + {1'b0, i_vy};

    always_comb begin
        o_alu = '0;
        unique case (i_func)
            c8_pkg::ALU_MOV: o_alu.res = i_vy;
            c8_pkg::ALU_OR:  o_alu.res = i_vx | i_vy;
            c8_pkg::ALU_AND: o_alu.res = i_vx & i_vy;
            c8_pkg::ALU_XOR: o_alu.res = i_vx ^ i_vy;
            c8_pkg::ALU_ADD: begin
                o_alu.res = sum[7:0];
                o_alu.vf = sum[8];
                o_alu.has_vf = 1'b1;
            end
            c8_pkg::ALU_SUB: begin
                o_alu.res = i_vx - i_vy;
                o_alu.vf = i_vx > i_vy;
                o_alu.has_vf = 1'b1;
            end
            c8_pkg::ALU_SHR: begin
                o_alu.res = {1'b0, i_vx[7:1]};
                o_alu.vf = i_vx[0];
                o_alu.has_vf = 1'b1;
            end
            c8_pkg::ALU_SBN: begin
                o_alu.res = i_vy - i_vx;
                o_alu.vf = i_vy > i_vx;
                o_alu.has_vf = 1'b1;
            end
            c8_pkg::ALU_SHL: begin
                o_alu.res = {i_vx[6:0], 1'b0};
                o_alu.vf = i_vx[7];
                o_alu.has_vf = 1'b1;
            end
            default: o_alu.bad = 1'b1;
        endcase
    end
endmodule

FILE: rtl/chip8_interpreter_core.sv
// Channel   Direction  Handshake         Payload
// request   in         i_valid/o_stall   i_req_type i_address i_write_data i_keys i_random_byte
// result    out        o_valid/i_stall   o_program_counter o_executed o_sound_active
//                                        o_bad_opcode o_stack_fault o_waiting_key
//                                        o_read_byte o_screen_row
// After reset a clearing pass over every memory address loads the font and clears the
// screen; requests are stalled during it. A write goes from issue to completion, a memory
// or row read adds a read state, and a step runs issue, two fetch, two register reads,
// execute and completion, plus a VF write or RET state, the Fx33 digit writes, a read
// and a write per sprite row for DRW, a read and a write per register for Fx55/Fx65 and
// a clear per screen row for CLS; the one-read-port memories set this sequencing.
// One request is processed at a time; a finished result waits in the output register
// while the next request is taken.
module chip8_interpreter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_keys,
    input  logic [7:0]  i_random_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_program_counter,
    output logic        o_executed,
    output logic        o_sound_active,
    output logic        o_bad_opcode,
    output logic        o_stack_fault,
    output logic        o_waiting_key,
    output logic [7:0]  o_read_byte,
    output logic [63:0] o_screen_row
);
    c8_pkg::t_state r_state, n_state;

    logic [1:0]  r_req;
    logic [11:0] r_addr;
    logic [7:0]  r_wdata;
    logic [15:0] r_keysin;
    logic [7:0]  r_rnd;
    logic [15:0] r_op;
    logic [7:0]  r_vx, r_vy;
    logic [11:0] r_pc, r_i;
    logic [7:0]  r_dt, r_st;
    logic [c8_pkg::SP_W-1:0] r_sp;
    logic [15:0] r_kn, r_kb;
    logic [4:0]  r_cnt;
    logic        r_hit, r_vfval;
    logic        r_res_exec, r_res_buzz, r_res_bad, r_res_fault, r_res_wait;
    logic [7:0]  r_res_byte;
    logic [63:0] r_res_row;
    logic [c8_pkg::MEM_AW-1:0] r_clr;
    logic [15:0] r_vvalid;
    logic        r_rvld;
    logic        r_o_valid;

    logic                      mem_we;
    logic [c8_pkg::MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]                mem_wdata, mem_rdata;
    logic                      scr_we;
    logic [c8_pkg::ROW_AW-1:0] scr_waddr, scr_raddr;
    logic [63:0]               scr_wdata, scr_rdata;
    logic                      v_we;
    logic [3:0]                v_waddr, v_raddr;
    logic [7:0]                v_wdata, v_rdata, vreg_q;
    logic                      stk_we;
    logic [c8_pkg::STK_AW-1:0] stk_waddr, stk_raddr;
    logic [11:0]               stk_wdata, stk_rdata;

    c8_pkg::t_alu alu;

    logic [3:0]  nib, x;
    logic [7:0]  kk;
    logic [11:0] nnn, pc_next, pc_skip;
    logic [8:0]  y9;
    logic        drow_ok, key_hit, halted, out_free, stk_full, key_new;
    logic [63:0] mask;
    logic [12:0] i_off;

    assign nib     = r_op[15:12];
    assign x       = r_op[11:8];
    assign kk      = r_op[7:0];
    assign nnn     = r_op[11:0];
    assign pc_next = r_pc + 12'd2;
    assign pc_skip = r_pc + 12'd4;
    assign y9      = {1'b0, r_vy} + {4'd0, r_cnt};
    assign drow_ok = y9 < 9'(c8_pkg::SCREEN_HEIGHT);
    assign mask    = (r_vx < 8'(c8_pkg::SCREEN_WIDTH)) ? ({mem_rdata, 56'd0} >> r_vx[5:0]) : '0;
    assign key_hit = (r_vx < 8'd16) && r_kn[r_vx[3:0]];
    assign halted  = (32'(r_pc) + 32'd1) >= 32'(c8_pkg::MEM_BYTES);
    assign out_free = !r_o_valid || !i_stall;
    assign stk_full = 32'(r_sp) >= 32'(c8_pkg::STACK_DEPTH);
    assign key_new = r_kn > r_kb;
    assign i_off   = {1'b0, r_i} + {8'd0, r_cnt};
    assign vreg_q  = r_rvld ? v_rdata : 8'd0;

    assign o_stall = (r_state != c8_pkg::ST_IDLE);
    assign o_valid = r_o_valid;

    c8_ram #(.W(8), .D(c8_pkg::MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );

    c8_ram #(.W(64), .D(c8_pkg::SCREEN_HEIGHT)) u_scr (
        .i_clk(i_clk), .i_we(scr_we), .i_waddr(scr_waddr), .i_wdata(scr_wdata),
        .i_raddr(scr_raddr), .o_rdata(scr_rdata)
    );

    c8_ram #(.W(8), .D(16)) u_vreg (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    c8_ram #(.W(12), .D(c8_pkg::STACK_DEPTH)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    c8_alu u_alu (.i_func(r_op[3:0]), .i_vx(r_vx), .i_vy(r_vy), .o_alu(alu));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            c8_pkg::ST_CLEAR: begin
                if (32'(r_clr) == c8_pkg::MEM_BYTES - 1) n_state = c8_pkg::ST_IDLE;
            end
            c8_pkg::ST_IDLE: begin
                if (i_valid) n_state = c8_pkg::ST_START;
            end
            c8_pkg::ST_START: begin
                unique case (r_req)
                    c8_pkg::REQ_WRITE: n_state = c8_pkg::ST_DONE;
                    c8_pkg::REQ_READ:  n_state = c8_pkg::ST_MEMRD;
                    c8_pkg::REQ_ROW:   n_state = c8_pkg::ST_ROWRD;
                    default:           n_state = halted ? c8_pkg::ST_DONE : c8_pkg::ST_FH;
                endcase
            end
            c8_pkg::ST_MEMRD, c8_pkg::ST_ROWRD, c8_pkg::ST_RET, c8_pkg::ST_WVF:
                n_state = c8_pkg::ST_DONE;
            c8_pkg::ST_FH: n_state = c8_pkg::ST_FL;
            c8_pkg::ST_FL: n_state = c8_pkg::ST_RX;
            c8_pkg::ST_RX: n_state = c8_pkg::ST_RY;
            c8_pkg::ST_RY: n_state = c8_pkg::ST_EX;
            c8_pkg::ST_EX: begin
                n_state = c8_pkg::ST_DONE;
                case (nib)
                    c8_pkg::OP_SYS: begin
                        if (r_op == c8_pkg::OPC_CLS) n_state = c8_pkg::ST_CLS;
                        else if (r_op == c8_pkg::OPC_RET && r_sp != '0) n_state = c8_pkg::ST_RET;
                    end
                    c8_pkg::OP_ALU: begin
                        if (alu.has_vf) n_state = c8_pkg::ST_WVF;
                    end
                    c8_pkg::OP_DRW: begin
                        n_state = (r_op[3:0] == 4'd0) ? c8_pkg::ST_WVF : c8_pkg::ST_D0;
                    end
                    c8_pkg::OP_MISC: begin
                        if (kk == c8_pkg::FX_BCD) n_state = c8_pkg::ST_BCD;
                        else if (kk == c8_pkg::FX_STORE) n_state = c8_pkg::ST_ST0;
                        else if (kk == c8_pkg::FX_LOAD) n_state = c8_pkg::ST_LD0;
                    end
                    default: n_state = c8_pkg::ST_DONE;
                endcase
            end
            c8_pkg::ST_CLS: begin
                if (32'(r_cnt) == c8_pkg::SCREEN_HEIGHT - 1) n_state = c8_pkg::ST_DONE;
            end
            c8_pkg::ST_D0: n_state = c8_pkg::ST_D1;
            c8_pkg::ST_D1: begin
                n_state = (r_cnt[3:0] + 4'd1 == r_op[3:0]) ? c8_pkg::ST_WVF : c8_pkg::ST_D0;
            end
            c8_pkg::ST_BCD: begin
                if (r_cnt == 5'd2) n_state = c8_pkg::ST_DONE;
            end
            c8_pkg::ST_ST0: n_state = c8_pkg::ST_ST1;
            c8_pkg::ST_ST1: begin
                n_state = (r_cnt == {1'b0, x}) ? c8_pkg::ST_DONE : c8_pkg::ST_ST0;
            end
            c8_pkg::ST_LD0: n_state = c8_pkg::ST_LD1;
            c8_pkg::ST_LD1: begin
                n_state = (r_cnt == {1'b0, x}) ? c8_pkg::ST_DONE : c8_pkg::ST_LD0;
            end
            c8_pkg::ST_DONE: begin
                if (out_free) n_state = c8_pkg::ST_IDLE;
            end
            default: n_state = c8_pkg::ST_IDLE;
        endcase
    end

    // Memory port controls.
    always_comb begin
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
        scr_we = 1'b0; scr_waddr = '0; scr_wdata = '0; scr_raddr = '0;
        v_we = 1'b0; v_waddr = '0; v_wdata = '0; v_raddr = '0;
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = pc_next; stk_raddr = '0;
        unique case (r_state)
            c8_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = c8_pkg::font_byte(r_clr);
                scr_we    = 32'(r_clr) < c8_pkg::SCREEN_HEIGHT;
                scr_waddr = r_clr[c8_pkg::ROW_AW-1:0];
            end
            c8_pkg::ST_START: begin
                mem_we    = (r_req == c8_pkg::REQ_WRITE);
                mem_waddr = c8_pkg::mem_idx({1'b0, r_addr});
                mem_wdata = r_wdata;
                mem_raddr = (r_req == c8_pkg::REQ_STEP) ? c8_pkg::mem_idx({1'b0, r_pc})
                                                        : c8_pkg::mem_idx({1'b0, r_addr});
                scr_raddr = r_addr[c8_pkg::ROW_AW-1:0];
            end
            c8_pkg::ST_FH: mem_raddr = c8_pkg::mem_idx({1'b0, r_pc} + 13'd1);
            c8_pkg::ST_FL: v_raddr = x;
            c8_pkg::ST_RX: v_raddr = (nib == c8_pkg::OP_JPV0) ? 4'd0 : r_op[7:4];
            c8_pkg::ST_EX: begin
                v_waddr = x;
                case (nib)
                    c8_pkg::OP_SYS: stk_raddr = r_sp[c8_pkg::STK_AW-1:0] - 1'b1;
                    c8_pkg::OP_CALL: begin
                        stk_we    = !stk_full;
                        stk_waddr = r_sp[c8_pkg::STK_AW-1:0];
                    end
                    c8_pkg::OP_LDK: begin
                        v_we = 1'b1; v_wdata = kk;
                    end
                    c8_pkg::OP_ADDK: begin
                        v_we = 1'b1; v_wdata = r_vx + kk;
                    end
                    c8_pkg::OP_RND: begin
                        v_we = 1'b1; v_wdata = r_rnd & kk;
                    end
                    c8_pkg::OP_ALU: begin
                        v_we = !alu.bad; v_wdata = alu.res;
                    end
                    c8_pkg::OP_MISC: begin
                        if (kk == c8_pkg::FX_GET_DT) begin
                            v_we = 1'b1; v_wdata = r_dt;
                        end else if (kk == c8_pkg::FX_WAITKEY) begin
                            v_we = key_new; v_wdata = {4'd0, c8_pkg::high_bit(r_kn)};
                        end
                    end
                    default: v_we = 1'b0;
                endcase
            end
            c8_pkg::ST_WVF: begin
                v_we = 1'b1; v_waddr = c8_pkg::REG_VF; v_wdata = {7'd0, r_vfval};
            end
            c8_pkg::ST_CLS: begin
                scr_we = 1'b1; scr_waddr = r_cnt[c8_pkg::ROW_AW-1:0];
            end
            c8_pkg::ST_D0: begin
                mem_raddr = c8_pkg::mem_idx(i_off);
                scr_raddr = y9[c8_pkg::ROW_AW-1:0];
            end
            c8_pkg::ST_D1: begin
                scr_we    = drow_ok;
                scr_waddr = y9[c8_pkg::ROW_AW-1:0];
                scr_wdata = scr_rdata ^ mask;
            end
            c8_pkg::ST_BCD: begin
                mem_we    = 1'b1;
                mem_waddr = c8_pkg::mem_idx(i_off);
                mem_wdata = c8_pkg::bcd_digit(r_vx, r_cnt[1:0]);
            end
            c8_pkg::ST_ST0: v_raddr = r_cnt[3:0];
            c8_pkg::ST_ST1: begin
                mem_we = 1'b1; mem_waddr = c8_pkg::mem_idx(i_off); mem_wdata = vreg_q;
            end
            c8_pkg::ST_LD0: mem_raddr = c8_pkg::mem_idx(i_off);
            c8_pkg::ST_LD1: begin
                v_we = 1'b1; v_waddr = r_cnt[3:0]; v_wdata = mem_rdata;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= c8_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_pc      <= c8_pkg::PC_START;
            r_i       <= '0;
            r_dt      <= '0;
            r_st      <= '0;
            r_sp      <= '0;
            r_kn      <= '0;
            r_kb      <= '0;
            r_vvalid  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rvld  <= r_vvalid[v_raddr];
            if (v_we) r_vvalid[v_waddr] <= 1'b1;
            if (r_state == c8_pkg::ST_DONE && out_free) r_o_valid <= 1'b1;
            else if (r_o_valid && !i_stall) r_o_valid <= 1'b0;

            unique case (r_state)
                c8_pkg::ST_CLEAR: r_clr <= r_clr + 1'b1;
                c8_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_req       <= i_req_type;
                        r_addr      <= i_address;
                        r_wdata     <= i_write_data;
                        r_keysin    <= i_keys;
                        r_rnd       <= i_random_byte;
                        r_res_exec  <= 1'b0;
                        r_res_buzz  <= 1'b0;
                        r_res_bad   <= 1'b0;
                        r_res_fault <= 1'b0;
                        r_res_wait  <= 1'b0;
                        r_res_byte  <= '0;
                        r_res_row   <= '0;
                    end
                end
                c8_pkg::ST_START: begin
                    if (r_req == c8_pkg::REQ_STEP && !halted) begin
                        r_kb <= r_kn;
                        r_kn <= r_keysin;
                        r_res_exec <= 1'b1;
                        if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                        if (r_st != 8'd0) begin
                            r_st <= r_st - 8'd1;
                            r_res_buzz <= 1'b1;
                        end
                    end
                end
                c8_pkg::ST_MEMRD: r_res_byte <= mem_rdata;
                c8_pkg::ST_ROWRD: begin
                    r_res_row <= (32'(r_addr) < c8_pkg::SCREEN_HEIGHT) ? scr_rdata : '0;
                end
                c8_pkg::ST_FH: r_op[15:8] <= mem_rdata;
                c8_pkg::ST_FL: r_op[7:0] <= mem_rdata;
                c8_pkg::ST_RX: r_vx <= vreg_q;
                c8_pkg::ST_RY: r_vy <= vreg_q;
                c8_pkg::ST_EX: begin
                    r_cnt   <= '0;
                    r_hit   <= 1'b0;
                    r_vfval <= 1'b0;
                    case (nib)
                        c8_pkg::OP_SYS: begin
                            if (r_op == c8_pkg::OPC_RET) begin
                                if (r_sp == '0) r_res_fault <= 1'b1;
                                else r_sp <= r_sp - 1'b1;
                                r_pc <= pc_next;
                            end else if (r_op == c8_pkg::OPC_CLS) begin
                                r_pc <= pc_next;
                            end else begin
                                r_pc <= nnn;
                            end
                        end
                        c8_pkg::OP_JP: r_pc <= nnn;
                        c8_pkg::OP_CALL: begin
                            if (stk_full) r_res_fault <= 1'b1;
                            else r_sp <= r_sp + 1'b1;
                            r_pc <= nnn;
                        end
                        c8_pkg::OP_SEK:  r_pc <= (r_vx == kk) ? pc_skip : pc_next;
                        c8_pkg::OP_SNEK: r_pc <= (r_vx != kk) ? pc_skip : pc_next;
                        c8_pkg::OP_SEV:  r_pc <= (r_vx == r_vy) ? pc_skip : pc_next;
                        c8_pkg::OP_SNEV: r_pc <= (r_vx != r_vy) ? pc_skip : pc_next;
                        c8_pkg::OP_ALU: begin
                            r_res_bad <= alu.bad;
                            r_vfval   <= alu.vf;
                            r_pc      <= pc_next;
                        end
                        c8_pkg::OP_LDI: begin
                            r_i  <= nnn;
                            r_pc <= pc_next;
                        end
                        c8_pkg::OP_JPV0: r_pc <= {4'd0, r_vy} + nnn;
                        c8_pkg::OP_KEY: begin
                            if (kk == c8_pkg::KEY_SKP) begin
                                r_pc <= key_hit ? pc_skip : pc_next;
                            end else if (kk == c8_pkg::KEY_SKNP) begin
                                r_pc <= key_hit ? pc_next : pc_skip;
                            end else begin
                                r_res_bad <= 1'b1;
                                r_pc      <= pc_next;
                            end
                        end
                        c8_pkg::OP_MISC: begin
                            // A key wait without a new key runs the same opcode again.
                            r_pc <= (kk == c8_pkg::FX_WAITKEY && !key_new) ? r_pc : pc_next;
                            case (kk)
                                c8_pkg::FX_GET_DT, c8_pkg::FX_BCD, c8_pkg::FX_STORE,
                                c8_pkg::FX_LOAD: begin
                                end
                                c8_pkg::FX_WAITKEY: begin
                                    if (!key_new) r_res_wait <= 1'b1;
                                end
                                c8_pkg::FX_SET_DT: r_dt <= r_vx;
                                c8_pkg::FX_SET_ST: r_st <= r_vx;
                                c8_pkg::FX_ADD_I:  r_i <= r_i + {4'd0, r_vx};
                                c8_pkg::FX_FONT: begin
                                    r_i <= 12'(c8_pkg::FONT_BASE) + ({4'd0, r_vx} << 2)
                                           + {4'd0, r_vx};
                                end
                                default: r_res_bad <= 1'b1;
                            endcase
                        end
                        default: r_pc <= pc_next;
                    endcase
                end
                c8_pkg::ST_RET: r_pc <= stk_rdata;
                c8_pkg::ST_D1: begin
                    if (drow_ok && ((scr_rdata & mask) != '0)) begin
                        r_hit   <= 1'b1;
                        r_vfval <= 1'b1;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                c8_pkg::ST_CLS, c8_pkg::ST_BCD, c8_pkg::ST_ST1, c8_pkg::ST_LD1:
                    r_cnt <= r_cnt + 5'd1;
                c8_pkg::ST_DONE: begin
                    if (out_free) begin
                        o_program_counter <= r_pc;
                        o_executed        <= r_res_exec;
                        o_sound_active    <= r_res_buzz;
                        o_bad_opcode      <= r_res_bad;
                        o_stack_fault     <= r_res_fault;
                        o_waiting_key     <= r_res_wait;
                        o_read_byte       <= r_res_byte;
                        o_screen_row      <= r_res_row;
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sp) <= c8_pkg::STACK_DEPTH)
        else $error("stack count beyond depth");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == c8_pkg::ST_DONE))
        else $error("result issued outside completion");

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c8_pkg::ST_CLEAR) |-> o_stall)
        else $error("request taken during clearing pass");

    a_hit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c8_pkg::ST_D0) |-> (r_hit == r_vfval))
        else $error("collision flag out of step");
endmodule

FILE: verif/tb_chip8_interpreter_core.sv
module tb_chip8_interpreter_core;

    typedef struct {
        logic [11:0] pc;
        logic        exe;
        logic        buzz;
        logic        bad;
        logic        fault;
        logic        wait_k;
        logic [7:0]  rbyte;
        logic [63:0] row;
    } t_reply;

    localparam logic [3:0] ALU_CODES [9] = '{c8_pkg::ALU_MOV, c8_pkg::ALU_OR,
        c8_pkg::ALU_AND, c8_pkg::ALU_XOR, c8_pkg::ALU_ADD, c8_pkg::ALU_SUB,
        c8_pkg::ALU_SHR, c8_pkg::ALU_SBN, c8_pkg::ALU_SHL};
    localparam logic [7:0] FX_CODES [9] = '{c8_pkg::FX_GET_DT, c8_pkg::FX_WAITKEY,
        c8_pkg::FX_SET_DT, c8_pkg::FX_SET_ST, c8_pkg::FX_ADD_I, c8_pkg::FX_FONT,
        c8_pkg::FX_BCD, c8_pkg::FX_STORE, c8_pkg::FX_LOAD};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [11:0] i_address;
    logic [7:0]  i_write_data;
    logic [15:0] i_keys;
    logic [7:0]  i_random_byte;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_program_counter;
    logic        o_executed;
    logic        o_sound_active;
    logic        o_bad_opcode;
    logic        o_stack_fault;
    logic        o_waiting_key;
    logic [7:0]  o_read_byte;
    logic [63:0] o_screen_row;

    chip8_interpreter_core dut (.*);

    // Shadow copy of the interpreter state.
    logic [7:0]  mem_img [c8_pkg::MEM_BYTES];
    logic [7:0]  vreg [16];
    logic [11:0] ireg;
    logic [11:0] pc_img;
    logic [7:0]  delay_t;
    logic [7:0]  sound_t;
    logic [11:0] call_stack [c8_pkg::STACK_DEPTH];
    int          call_depth;
    logic [15:0] keys_cur;
    logic [15:0] keys_prev;
    logic [63:0] pixels [c8_pkg::SCREEN_HEIGHT];

    t_reply pending_replies [$];
    int     error_count;
    bit     no_idle;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_reply exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                exp_r = pending_replies.pop_front();
                check_field("program_counter", 64'(o_program_counter), 64'(exp_r.pc));
                check_field("executed", 64'(o_executed), 64'(exp_r.exe));
                check_field("sound_active", 64'(o_sound_active), 64'(exp_r.buzz));
                check_field("bad_opcode", 64'(o_bad_opcode), 64'(exp_r.bad));
                check_field("stack_fault", 64'(o_stack_fault), 64'(exp_r.fault));
                check_field("waiting_key", 64'(o_waiting_key), 64'(exp_r.wait_k));
                check_field("read_byte", 64'(o_read_byte), 64'(exp_r.rbyte));
                check_field("screen_row", o_screen_row, exp_r.row);
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= !no_idle && ($urandom_range(99) < 18);
    end

    function automatic void reset_shadow();
        for (int a = 0; a < c8_pkg::MEM_BYTES; a++) mem_img[a] = 8'h00;
        for (int a = 0; a < c8_pkg::FONT_BYTES; a++) begin
            mem_img[c8_pkg::FONT_BASE + a] = c8_pkg::GLYPHS[a];
        end
        for (int r = 0; r < 16; r++) vreg[r] = 8'h00;
        for (int r = 0; r < c8_pkg::SCREEN_HEIGHT; r++) pixels[r] = 64'd0;
        ireg = 12'd0;
        pc_img = c8_pkg::PC_START;
        delay_t = 8'd0;
        sound_t = 8'd0;
        call_depth = 0;
        keys_cur = 16'd0;
        keys_prev = 16'd0;
    endfunction

    function automatic void draw_sprite(input logic [7:0] px, input logic [7:0] py,
                                        input int rows);
        logic [7:0] line;
        logic       hit;
        int         yy;
        int         xx;
        hit = 1'b0;
        for (int r = 0; r < rows; r++) begin
            yy = py + r;
            line = mem_img[12'(ireg + r)];
            if (yy < c8_pkg::SCREEN_HEIGHT) begin
                for (int c = 0; c < 8; c++) begin
                    xx = px + c;
                    if (line[7 - c] && xx < c8_pkg::SCREEN_WIDTH) begin
                        if (pixels[yy][63 - xx]) hit = 1'b1;
                        pixels[yy][63 - xx] = !pixels[yy][63 - xx];
                    end
                end
            end
        end
        vreg[c8_pkg::REG_VF] = {7'd0, hit};
    endfunction

    function automatic void execute_opcode(input logic [15:0] op, input logic [7:0] rnd,
                                           inout t_reply rep);
        logic [11:0] nnn;
        logic [7:0]  kk;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [11:0] nxt;
        logic [8:0]  sum;
        logic        held;
        nnn = op[11:0];
        kk = op[7:0];
        x = op[11:8];
        y = op[7:4];
        vx = vreg[x];
        vy = vreg[y];
        nxt = pc_img + 12'd2;
        held = (vx < 16) && keys_cur[vx[3:0]];
        case (op[15:12])
            c8_pkg::OP_SYS: begin
                if (op == c8_pkg::OPC_CLS) begin
                    for (int r = 0; r < c8_pkg::SCREEN_HEIGHT; r++) pixels[r] = 64'd0;
                    pc_img = nxt;
                end else if (op == c8_pkg::OPC_RET) begin
                    if (call_depth == 0) begin
                        rep.fault = 1'b1;
                        pc_img = nxt;
                    end else begin
                        call_depth--;
                        pc_img = call_stack[call_depth];
                    end
                end else begin
                    pc_img = nnn;
                end
            end
            c8_pkg::OP_JP: pc_img = nnn;
            c8_pkg::OP_CALL: begin
                if (call_depth < c8_pkg::STACK_DEPTH) begin
                    call_stack[call_depth] = nxt;
                    call_depth++;
                end else begin
                    rep.fault = 1'b1;
                end
                pc_img = nnn;
            end
            c8_pkg::OP_SEK: pc_img = nxt + ((vx == kk) ? 12'd2 : 12'd0);
            c8_pkg::OP_SNEK: pc_img = nxt + ((vx != kk) ? 12'd2 : 12'd0);
            c8_pkg::OP_SEV: pc_img = nxt + ((vx == vy) ? 12'd2 : 12'd0);
            c8_pkg::OP_SNEV: pc_img = nxt + ((vx != vy) ? 12'd2 : 12'd0);
            c8_pkg::OP_LDK: begin
                vreg[x] = kk;
                pc_img = nxt;
            end
            c8_pkg::OP_ADDK: begin
                vreg[x] = vx + kk;
                pc_img = nxt;
            end
            c8_pkg::OP_ALU: begin
                // The flag is written after the result, so it wins when x is VF.
                case (op[3:0])
                    c8_pkg::ALU_MOV: vreg[x] = vy;
                    c8_pkg::ALU_OR:  vreg[x] = vx | vy;
                    c8_pkg::ALU_AND: vreg[x] = vx & vy;
                    c8_pkg::ALU_XOR: vreg[x] = vx ^ vy;
                    c8_pkg::ALU_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = sum[7:0];
                        vreg[c8_pkg::REG_VF] = {7'd0, sum[8]};
                    end
                    c8_pkg::ALU_SUB: begin
                        vreg[x] = vx - vy;
                        vreg[c8_pkg::REG_VF] = {7'd0, vx > vy};
                    end
                    c8_pkg::ALU_SHR: begin
                        vreg[x] = vx >> 1;
                        vreg[c8_pkg::REG_VF] = {7'd0, vx[0]};
                    end
                    c8_pkg::ALU_SBN: begin
                        vreg[x] = vy - vx;
                        vreg[c8_pkg::REG_VF] = {7'd0, vy > vx};
                    end
                    c8_pkg::ALU_SHL: begin
                        vreg[x] = vx << 1;
                        vreg[c8_pkg::REG_VF] = {7'd0, vx[7]};
                    end
                    default: rep.bad = 1'b1;
                endcase
                pc_img = nxt;
            end
            c8_pkg::OP_LDI: begin
                ireg = nnn;
                pc_img = nxt;
            end
            c8_pkg::OP_JPV0: pc_img = 12'(vreg[0]) + nnn;
            c8_pkg::OP_RND: begin
                vreg[x] = rnd & kk;
                pc_img = nxt;
            end
            c8_pkg::OP_DRW: begin
                draw_sprite(vx, vy, int'(op[3:0]));
                pc_img = nxt;
            end
            c8_pkg::OP_KEY: begin
                if (kk == c8_pkg::KEY_SKP) pc_img = nxt + (held ? 12'd2 : 12'd0);
                else if (kk == c8_pkg::KEY_SKNP) pc_img = nxt + (held ? 12'd0 : 12'd2);
                else begin
                    rep.bad = 1'b1;
                    pc_img = nxt;
                end
            end
            default: begin
                case (kk)
                    c8_pkg::FX_GET_DT: vreg[x] = delay_t;
                    c8_pkg::FX_WAITKEY: begin
                        if (keys_cur > keys_prev) begin
                            vreg[x] = 8'd0;
                            for (int b = 1; b < 16; b++) begin
                                if (keys_cur[b]) vreg[x] = 8'(b);
                            end
                        end else begin
                            nxt = pc_img;
                            rep.wait_k = 1'b1;
                        end
                    end
                    c8_pkg::FX_SET_DT: delay_t = vx;
                    c8_pkg::FX_SET_ST: sound_t = vx;
                    c8_pkg::FX_ADD_I: ireg = ireg + 12'(vx);
                    c8_pkg::FX_FONT: ireg = 12'(c8_pkg::FONT_BASE) + 12'(vx) * 12'd5;
                    c8_pkg::FX_BCD: begin
                        mem_img[ireg] = 8'(vx / 100);
                        mem_img[12'(ireg + 1)] = 8'((vx / 10) % 10);
                        mem_img[12'(ireg + 2)] = 8'(vx % 10);
                    end
                    c8_pkg::FX_STORE: begin
                        for (int r = 0; r <= x; r++) mem_img[12'(ireg + r)] = vreg[r];
                    end
                    c8_pkg::FX_LOAD: begin
                        for (int r = 0; r <= x; r++) vreg[r] = mem_img[12'(ireg + r)];
                    end
                    default: rep.bad = 1'b1;
                endcase
                pc_img = nxt;
            end
        endcase
    endfunction

    function automatic void predict_request(input logic [1:0] req, input logic [11:0] addr,
                                            input logic [7:0] wdata, input logic [15:0] keys,
                                            input logic [7:0] rnd);
        t_reply rep;
        rep = '{default: '0};
        case (req)
            c8_pkg::REQ_WRITE: mem_img[addr] = wdata;
            c8_pkg::REQ_READ:  rep.rbyte = mem_img[addr];
            c8_pkg::REQ_ROW: begin
                if (addr < c8_pkg::SCREEN_HEIGHT) rep.row = pixels[addr];
            end
            default: begin
                if (32'(pc_img) + 1 < c8_pkg::MEM_BYTES) begin
                    keys_prev = keys_cur;
                    keys_cur = keys;
                    if (delay_t != 0) delay_t--;
                    if (sound_t != 0) begin
                        sound_t--;
                        rep.buzz = 1'b1;
                    end
                    execute_opcode({mem_img[pc_img], mem_img[12'(pc_img + 1)]}, rnd, rep);
                    rep.exe = 1'b1;
                end
            end
        endcase
        rep.pc = pc_img;
        pending_replies.push_back(rep);
    endfunction

    // Drives one request and returns once it is accepted; valid stays high.
    task automatic send_request(input logic [1:0] req, input logic [11:0] addr,
                                input logic [7:0] wdata, input logic [15:0] keys,
                                input logic [7:0] rnd);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 18) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req_type = req;
        i_address = addr;
        i_write_data = wdata;
        i_keys = keys;
        i_random_byte = rnd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(req, addr, wdata, keys, rnd);
    endtask

    task automatic step_core(input logic [15:0] keys, input logic [7:0] rnd);
        send_request(c8_pkg::REQ_STEP, 12'($urandom), 8'($urandom), keys, rnd);
    endtask

    // Places an opcode at the current program counter and executes it.
    task automatic run_opcode(input logic [15:0] op, input logic [15:0] keys,
                              input logic [7:0] rnd);
        send_request(c8_pkg::REQ_WRITE, pc_img, op[15:8], 16'($urandom), 8'($urandom));
        send_request(c8_pkg::REQ_WRITE, 12'(pc_img + 1), op[7:0], 16'($urandom),
                     8'($urandom));
        step_core(keys, rnd);
    endtask

    task automatic test_memory_access();
        send_request(c8_pkg::REQ_WRITE, 12'h000, 8'hFF, 16'hFFFF, 8'hFF);
        send_request(c8_pkg::REQ_WRITE, 12'hFFF, 8'h00, 16'h0000, 8'h00);
        send_request(c8_pkg::REQ_READ, 12'h000, 8'h00, 16'h0000, 8'h00);
        send_request(c8_pkg::REQ_READ, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_request(c8_pkg::REQ_READ, 12'(c8_pkg::FONT_BASE), 8'h00, 16'h0000, 8'h00);
        send_request(c8_pkg::REQ_ROW, 12'd0, 8'h00, 16'h0000, 8'h00);
        send_request(c8_pkg::REQ_ROW, 12'd31, 8'h00, 16'h0000, 8'h00);
        send_request(c8_pkg::REQ_ROW, 12'd32, 8'h00, 16'h0000, 8'h00);
        send_request(c8_pkg::REQ_ROW, 12'hFFF, 8'h00, 16'h0000, 8'h00);
    endtask

    task automatic test_directed_opcodes();
        run_opcode({c8_pkg::OP_LDK, 4'h0, 8'hFF}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_LDK, 4'hF, 8'h01}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_ALU, 4'hF, 4'h0, c8_pkg::ALU_ADD}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_ALU, 4'h1, 4'h0, c8_pkg::ALU_SUB}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_ALU, 4'h0, 4'h1, c8_pkg::ALU_SHL}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_ALU, 4'h1, 4'h0, 4'h8}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_LDK, 4'h2, 8'd60}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_LDK, 4'h3, 8'd30}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_MISC, 4'h2, c8_pkg::FX_SET_ST}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_MISC, 4'h0, c8_pkg::FX_FONT}, 16'h0000, 8'h00);
        // Sprite at the lower right corner, drawn twice for a collision.
        run_opcode({c8_pkg::OP_DRW, 4'h2, 4'h3, 4'hF}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_DRW, 4'h2, 4'h3, 4'hF}, 16'h0000, 8'h00);
        send_request(c8_pkg::REQ_ROW, 12'd31, 8'h00, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_KEY, 4'h2, c8_pkg::KEY_SKP}, 16'hFFFF, 8'h00);
        run_opcode({c8_pkg::OP_KEY, 4'h2, 8'h00}, 16'hFFFF, 8'h00);
        run_opcode({c8_pkg::OP_MISC, 4'h5, c8_pkg::FX_WAITKEY}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_MISC, 4'h5, c8_pkg::FX_WAITKEY}, 16'h8000, 8'h00);
        run_opcode({c8_pkg::OP_MISC, 4'h0, 8'hFF}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_MISC, 4'hF, c8_pkg::FX_STORE}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_MISC, 4'h0, c8_pkg::FX_BCD}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_MISC, 4'hF, c8_pkg::FX_LOAD}, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_RND, 4'h4, 8'hFF}, 16'h0000, 8'hA5);
        run_opcode(c8_pkg::OPC_CLS, 16'h0000, 8'h00);
        run_opcode(c8_pkg::OPC_RET, 16'h0000, 8'h00);
        run_opcode({c8_pkg::OP_SYS, 12'h300}, 16'h0000, 8'h00);
    endtask

    task automatic test_stack_overflow();
        run_opcode({c8_pkg::OP_CALL, pc_img}, 16'h0000, 8'h00);
        repeat (c8_pkg::STACK_DEPTH) step_core(16'h0000, 8'h00);
        repeat (c8_pkg::STACK_DEPTH + 1) run_opcode(c8_pkg::OPC_RET, 16'h0000, 8'h00);
    endtask

    function automatic logic [15:0] random_opcode();
        logic [3:0]  hi;
        logic [11:0] low;
        logic [11:0] dest;
        hi = 4'($urandom);
        low = 12'($urandom);
        // Jump targets stay low, so the program counter rarely reaches the end.
        dest = 12'($urandom_range(12'hEFF, 12'h200));
        case (hi)
            c8_pkg::OP_SYS: begin
                if ($urandom_range(99) < 5) return c8_pkg::OPC_CLS;
                if ($urandom_range(99) < 45) return c8_pkg::OPC_RET;
                return {c8_pkg::OP_SYS, dest};
            end
            c8_pkg::OP_JP, c8_pkg::OP_CALL, c8_pkg::OP_JPV0: return {hi, dest};
            c8_pkg::OP_ALU: begin
                if ($urandom_range(99) < 10) return {hi, low};
                return {hi, low[11:4], ALU_CODES[$urandom_range(8)]};
            end
            c8_pkg::OP_KEY: begin
                if ($urandom_range(99) < 10) return {hi, low};
                return {hi, low[11:8], ($urandom_range(1) ? c8_pkg::KEY_SKP
                                                          : c8_pkg::KEY_SKNP)};
            end
            c8_pkg::OP_MISC: begin
                if ($urandom_range(99) < 10) return {hi, low};
                return {hi, low[11:8], FX_CODES[$urandom_range(8)]};
            end
            default: return {hi, low};
        endcase
    endfunction

    task automatic test_random_program();
        int unsigned pick;
        logic [15:0] keys;
        keys = 16'd0;
        for (int n = 0; n < 210; n++) begin
            no_idle = (n >= 60 && n < 100);
            pick = $urandom_range(99);
            if ($urandom_range(1)) keys = 16'($urandom);
            if (pick < 78) begin
                run_opcode(random_opcode(), keys, 8'($urandom));
            end else if (pick < 88) begin
                send_request(c8_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
            end else if (pick < 95) begin
                send_request(c8_pkg::REQ_ROW, ($urandom_range(3) == 0) ? 12'($urandom)
                             : 12'($urandom_range(35)), 8'($urandom), 16'($urandom),
                             8'($urandom));
            end else begin
                send_request(c8_pkg::REQ_WRITE, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // Leaves the core parked at the last address, so it runs last.
    task automatic test_halted_step();
        run_opcode({c8_pkg::OP_JP, 12'hFFF}, 16'h1234, 8'h00);
        step_core(16'hFFFF, 8'hFF);
        step_core(16'h0000, 8'h00);
        send_request(c8_pkg::REQ_READ, 12'hFFF, 8'h00, 16'h0000, 8'h00);
    endtask

    initial begin
        int waited;
        error_count = 0;
        no_idle = 1'b0;
        i_valid = 1'b0;
        i_req_type = c8_pkg::REQ_WRITE;
        i_address = '0;
        i_write_data = '0;
        i_keys = '0;
        i_random_byte = '0;
        i_rst_n = 1'b0;
        reset_shadow();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_memory_access();
        test_directed_opcodes();
        test_stack_overflow();
        test_random_program();
        test_halted_step();

        @(negedge i_clk);
        i_valid = 1'b0;
        waited = 0;
        while (pending_replies.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_replies.size()));
        end
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
